// File: rtl/atce_pkg.sv
// Package for the ANSI terminal cursor engine.
// Command/fault codes, phases, characters, result/command/status types; no dependencies.
package atce_pkg;
    localparam logic [2:0] CMD_PRINT = 3'd0;
    localparam logic [2:0] CMD_PAINT = 3'd1;
    localparam logic [2:0] CMD_SCROLL = 3'd2;
    localparam logic [2:0] CMD_ERASE = 3'd3;
    localparam logic [2:0] CMD_FAULT = 3'd4;

    localparam logic [2:0] FLT_TAB = 3'd1;
    localparam logic [2:0] FLT_MALFORMED = 3'd2;
    localparam logic [2:0] FLT_UNSUPPORTED = 3'd3;
    localparam logic [2:0] FLT_BAD_ARG = 3'd4;
    localparam logic [2:0] FLT_ROW_RANGE = 3'd5;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PREFIX = 2'd1;
    localparam logic [1:0] PH_NUM = 2'd2;
    localparam logic [1:0] PH_SEMI = 2'd3;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [3:0] COLOR_DEFAULT = 4'd9;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] col;
        logic [6:0] row;
        logic [7:0] end_col;
        logic [6:0] end_row;
        logic [7:0] glyph;
        logic [3:0] fg_code;
        logic [3:0] bg_code;
        logic [2:0] fault_code;
        logic       last;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic start;    // latch byte, process immediate part
        logic sgr_step; // apply one stored SGR argument
        logic finish;   // finalize cursor, build results
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_sgr;
        logic sgr_done;
    } t_status;
endpackage

// File: rtl/atce_ctrl.sv
// Sequencer of the cursor engine: start, SGR walk, finish.
// Depends on atce_pkg.
module atce_ctrl import atce_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_res_busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SGR = 2'd1;
    localparam logic [1:0] S_FIN = 2'd2;

    logic [1:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE) && !i_res_busy;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_state = S_SGR;
                end
            end
            S_SGR: begin
                if (i_status.need_sgr && !i_status.sgr_done) o_cmd.sgr_step = 1'b1;
                else n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

// File: rtl/atce_datapath.sv
// Datapath of the cursor engine: parser state, argument store, cursor,
// colors and result builder. Depends on atce_pkg.
module atce_datapath import atce_pkg::*; #(
    parameter int MAX_ARGS = 16,
    parameter int ARG_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_char,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    output t_status    o_status,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic [1:0] o_res_n
);
    localparam int CW = $clog2(MAX_ARGS + 1);
    localparam int IW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam logic [ARG_BITS-1:0] ARG_MAX = '1;

    logic [8:0] r_cols;
    logic [7:0] r_rows;
    logic [7:0] r_ccol;
    logic [6:0] r_crow;
    logic r_wrap;
    logic [1:0] r_phase;
    logic r_csi, r_priv, r_paren;
    logic [ARG_BITS-1:0] r_args [MAX_ARGS];
    logic [CW-1:0] r_argc;
    logic r_ovf;
    logic [3:0] r_fg, r_bg;
    logic [7:0] r_c;
    logic [CW-1:0] r_si;
    logic r_sgr, r_sgr_fault;

    // window bounds (widened, clamped to 2..256 columns and 1..128 rows)
    logic [9:0] w_w, w_h;
    always_comb begin
        w_w = (r_cols < 9'd2) ? 10'd2 : ((r_cols > 9'd256) ? 10'd256 : {1'b0, r_cols});
        w_h = (r_rows < 8'd1) ? 10'd1 : ((r_rows > 8'd128) ? 10'd128 : {2'b0, r_rows});
    end

    // arguments snapshot for the command
    logic [ARG_BITS-1:0] a0v, a1v;
    assign a0v = (r_argc > 0) ? r_args[0] : '0;
    assign a1v = (r_argc > 1) ? r_args[1] : '0;

    assign o_status.need_sgr = r_sgr;
    assign o_status.sgr_done = r_sgr_fault || (r_si >= r_argc);

    // widening helper: zero-extends an argument to 34 bits
    function automatic logic [33:0] sx(input logic [ARG_BITS-1:0] v);
        sx = 34'(v);
    endfunction

    // finish combinational evaluation (one per byte, in S_FIN)
    logic signed [33:0] cx, cy, ww, wh;
    logic [1:0] rn;
    t_result r0, r1, rr;
    logic wrap_n, paint;
    logic [1:0] ph_n;
    logic setcsi, setpriv, setparen, clrseq;
    logic st_arg, add_dg;
    logic [3:0] dg;
    logic run;
    logic digit;

    function automatic t_result mk(input logic [2:0] cmd, input logic [2:0] fc);
        t_result t;
        t = '0;
        t.command = cmd;
        t.fault_code = fc;
        return t;
    endfunction

    always_comb begin
        ww = 34'(w_w);
        wh = 34'(w_h);
        cx = 34'(r_ccol);
        cy = 34'(r_crow);
        if (cx > ww - 1) cx = ww - 1;
        if (cy > wh - 1) cy = wh - 1;
        rn = 2'd0;
        r0 = '0;
        r1 = '0;
        rr = '0;
        wrap_n = r_wrap;
        paint = 1'b0;
        ph_n = r_phase;
        setcsi = 1'b0; setpriv = 1'b0; setparen = 1'b0; clrseq = 1'b0;
        st_arg = 1'b0; add_dg = 1'b0; run = 1'b0;
        digit = (r_c >= "0") && (r_c <= "9");
        dg = 4'(r_c - "0");
        if (r_phase != PH_IDLE) begin
            if (r_phase == PH_PREFIX) begin
                if (r_c == "[" && !r_csi && !r_priv && !r_paren) setcsi = 1'b1;
                else if (r_c == "?" && !r_priv && !r_paren) setpriv = 1'b1;
                else if (r_c == ")" && !r_paren) setparen = 1'b1;
                else if (digit && r_csi) begin
                    st_arg = 1'b1; add_dg = 1'b1; ph_n = PH_NUM;
                end else run = 1'b1;
            end else if (r_phase == PH_NUM) begin
                if (digit) add_dg = 1'b1;
                else if (r_c == ";") ph_n = PH_SEMI;
                else run = 1'b1;
            end else begin
                if (digit) begin
                    st_arg = 1'b1; add_dg = 1'b1; ph_n = PH_NUM;
                end else begin
                    ph_n = PH_IDLE; rr = mk(CMD_FAULT, FLT_MALFORMED); rn = 2'd1;
                end
            end
            if (run) begin
                ph_n = PH_IDLE;
                if (!r_csi) begin
                    if (r_priv) begin rr = mk(CMD_FAULT, FLT_MALFORMED); rn = 2'd1; end
                    else if (r_paren) begin
                        if (r_c != "0") begin rr = mk(CMD_FAULT, FLT_UNSUPPORTED); rn = 2'd1; end
                    end else if (r_c == "M") cy = cy - 1;
                    else begin rr = mk(CMD_FAULT, FLT_UNSUPPORTED); rn = 2'd1; end
                end else if (r_paren) begin
                    rr = mk(CMD_FAULT, FLT_MALFORMED); rn = 2'd1;
                end else if (r_ovf) begin
                    rr = mk(CMD_FAULT, FLT_BAD_ARG); rn = 2'd1;
                end else if (r_priv) begin
                    if (r_c != "h") begin rr = mk(CMD_FAULT, FLT_UNSUPPORTED); rn = 2'd1; end
                    else if (r_argc != 1 || a0v != 7) begin
                        rr = mk(CMD_FAULT, FLT_BAD_ARG); rn = 2'd1;
                    end
                end else begin
                    rr = mk(CMD_FAULT, FLT_BAD_ARG);
                    case (r_c)
                        "H", "f": begin
                            if (r_argc == 0) begin cx = 0; cy = 0; end
                            else if (r_argc == 2) begin cy = sx(a0v) - 1; cx = sx(a1v) - 1; end
                            else rn = 2'd1;
                        end
                        "A": if (r_argc == 1) cy = cy - sx(a0v); else rn = 2'd1;
                        "B": if (r_argc == 1) cy = cy + sx(a0v); else rn = 2'd1;
                        "C": if (r_argc == 1) cx = cx + sx(a0v); else rn = 2'd1;
                        "D": if (r_argc == 1) cx = cx - sx(a0v); else rn = 2'd1;
                        "E": if (r_argc == 1) begin cy = cy + sx(a0v); cx = 0; end
                             else rn = 2'd1;
                        "F": if (r_argc == 1) begin cy = cy - sx(a0v); cx = 0; end
                             else rn = 2'd1;
                        "G": if (r_argc == 1) cx = sx(a0v) - 1; else rn = 2'd1;
                        "d": if (r_argc == 1) cy = sx(a0v) - 1; else rn = 2'd1;
                        "J": begin
                            if (r_argc > 1 || a0v > 2) rn = 2'd1;
                            else begin
                                rr = mk(CMD_ERASE, 3'd0); rn = 2'd1;
                                rr.end_col = 8'(ww - 1); rr.end_row = 7'(wh - 1);
                                if (a0v == 0) begin rr.col = 8'(cx); rr.row = 7'(cy); end
                                else if (a0v == 1) begin
                                    rr.end_col = 8'(cx); rr.end_row = 7'(cy);
                                end
                            end
                        end
                        "K": begin
                            if (r_argc > 1) rn = 2'd1;
                            else if (a0v <= 2) begin
                                rr = mk(CMD_ERASE, 3'd0); rn = 2'd1;
                                rr.row = 7'(cy); rr.end_row = 7'(cy);
                                rr.end_col = 8'(ww - 1);
                                if (a0v == 0) rr.col = 8'(cx);
                                else if (a0v == 1) rr.end_col = 8'(cx);
                            end
                        end
                        "m": begin
                            if (r_sgr_fault) rn = 2'd1;
                        end
                        "r": if (r_argc != 2 || a0v != 1 || sx(a1v) != wh) rn = 2'd1;
                        "l": if (r_argc != 1 || a0v != 4) rn = 2'd1;
                        default: begin rr = mk(CMD_FAULT, FLT_UNSUPPORTED); rn = 2'd1; end
                    endcase
                end
            end
        end else if (r_c == 8'h0A || r_c == 8'h0D) begin
            cx = 0;
            cy = cy + 1;
            if (cy >= wh) begin rr = mk(CMD_SCROLL, 3'd0); rn = 2'd1; cy = wh - 1; end
        end else if (r_c == CH_BS) begin
            cx = cx - 1;
            paint = 1'b1;
        end else if (r_c == 8'h09) begin
            rr = mk(CMD_FAULT, FLT_TAB); rn = 2'd1;
        end else if (r_c == 8'h0F || r_c == 8'h07) begin
        end else if (r_c == CH_ESC) begin
            ph_n = PH_PREFIX;
            clrseq = 1'b1;
        end else begin
            if (r_wrap) begin
                cx = 0;
                cy = cy + 1;
                wrap_n = 1'b0;
                if (cy >= wh) begin r0 = mk(CMD_SCROLL, 3'd0); rn = 2'd1; cy = wh - 1; end
            end
            rr = mk(CMD_PRINT, 3'd0);
            rr.col = 8'(cx); rr.row = 7'(cy); rr.glyph = r_c;
            rr.fg_code = r_fg; rr.bg_code = r_bg;
            if (rn == 2'd0) r0 = rr; else r1 = rr;
            rn = rn + 2'd1;
            cx = cx + 1;
            if (cx >= ww) wrap_n = 1'b1;
        end
        if (rn == 2'd1 && r1 == '0) r0 = rr;
        if (cx >= ww) cx = ww - 1;
        if (cx < ww - 1) wrap_n = 1'b0;
        if (cx < 0) cx = 0;
        if (cy < 0) cy = 0;
        if (cy >= wh) begin
            if (rn == 2'd0) r0 = mk(CMD_FAULT, FLT_ROW_RANGE);
            else if (rn == 2'd1) begin r1 = mk(CMD_FAULT, FLT_ROW_RANGE); end
            if (rn != 2'd2) rn = rn + 2'd1;
            cy = wh - 1;
        end
        if (paint) begin
            rr = mk(CMD_PAINT, 3'd0);
            rr.col = 8'(cx); rr.row = 7'(cy); rr.bg_code = COLOR_DEFAULT;
            if (rn == 2'd0) r0 = rr; else if (rn == 2'd1) r1 = rr;
            if (rn != 2'd2) rn = rn + 2'd1;
        end
        if (rn == 2'd1) r0.last = 1'b1;
        if (rn == 2'd2) r1.last = 1'b1;
    end

    // argument digit accumulate (one multiply-by-ten, saturating)
    logic [IW-1:0] li;
    logic [ARG_BITS+4:0] acc;
    logic [CW-1:0] argc_n;
    always_comb begin
        argc_n = r_argc;
        if (st_arg && r_argc < CW'(MAX_ARGS)) argc_n = r_argc + 1'b1;
        li = IW'(argc_n - 1'b1);
        acc = (st_arg ? '0 : ((ARG_BITS+5)'(r_args[li]) * (ARG_BITS+5)'(10))) +
              (ARG_BITS+5)'(dg);
        if (acc > (ARG_BITS+5)'(ARG_MAX)) acc = (ARG_BITS+5)'(ARG_MAX);
    end

    logic [ARG_BITS-1:0] sa;
    assign sa = r_args[IW'(r_si)];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_c <= i_char;
        end
        if (i_cmd.finish && add_dg && !(st_arg && r_argc >= CW'(MAX_ARGS)) && !r_ovf &&
            argc_n != 0)
            r_args[li] <= acc[ARG_BITS-1:0];
        if (i_cmd.sgr_step) r_si <= r_si + 1'b1;
        if (i_cmd.start) begin
            r_si <= '0;
        end
        if (!i_rst_n) begin
            r_cols <= 9'd80; r_rows <= 8'd25;
            r_ccol <= '0; r_crow <= '0; r_wrap <= 1'b0;
            r_phase <= PH_IDLE; r_csi <= 1'b0; r_priv <= 1'b0; r_paren <= 1'b0;
            r_argc <= '0; r_ovf <= 1'b0;
            r_fg <= COLOR_DEFAULT; r_bg <= COLOR_DEFAULT;
            r_sgr <= 1'b0; r_sgr_fault <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (!i_cfg_idx) r_cols <= i_cfg_data;
                else r_rows <= i_cfg_data[7:0];
            end
            if (i_cmd.start) begin
                r_sgr_fault <= 1'b0;
                // SGR needs the walk before finishing
                r_sgr <= (r_phase != PH_IDLE) && (r_phase != PH_SEMI) &&
                    r_csi && !r_paren && !r_ovf && !r_priv && (i_char == "m") &&
                    !(r_phase == PH_PREFIX && (i_char == "[" || i_char == "?" ||
                      i_char == ")"));
                if (r_phase != PH_IDLE && r_csi && !r_paren && !r_ovf && !r_priv &&
                    i_char == "m" && r_argc == 0 &&
                    (r_phase == PH_PREFIX || r_phase == PH_NUM)) begin
                    r_fg <= COLOR_DEFAULT; r_bg <= COLOR_DEFAULT;
                end
            end
            if (i_cmd.sgr_step) begin
                if (sa == 0) begin r_fg <= COLOR_DEFAULT; r_bg <= COLOR_DEFAULT; end
                else if (sa >= 30 && sa <= 38) r_fg <= 4'(sa - 30);
                else if (sa >= 40 && sa <= 48) r_bg <= 4'(sa - 40);
                else if (sa == 39) r_fg <= COLOR_DEFAULT;
                else if (sa == 49) r_bg <= COLOR_DEFAULT;
                else if (sa == 1) begin end
                else r_sgr_fault <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_ccol <= 8'(cx); r_crow <= 7'(cy); r_wrap <= wrap_n;
                r_phase <= ph_n;
                if (clrseq) begin
                    r_csi <= 1'b0; r_priv <= 1'b0; r_paren <= 1'b0;
                    r_argc <= '0; r_ovf <= 1'b0;
                end
                if (setcsi) r_csi <= 1'b1;
                if (setpriv) r_priv <= 1'b1;
                if (setparen) r_paren <= 1'b1;
                if (st_arg) begin
                    if (r_argc < CW'(MAX_ARGS)) r_argc <= argc_n;
                    else r_ovf <= 1'b1;
                end
            end
        end
    end

    assign o_res0 = r0;
    assign o_res1 = r1;
    assign o_res_n = i_cmd.finish ? rn : 2'd0;
endmodule

// File: rtl/atce_outq.sv
// Two-entry result buffer feeding the master stream.
// Depends on atce_pkg.
module atce_outq import atce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_result    i_res0,
    input  t_result    i_res1,
    input  logic [1:0] i_res_n,
    output logic       o_busy,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);
    t_result r_q0, r_q1;
    logic [1:0] r_cnt;

    assign o_busy = (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res = r_q0;

    always_ff @(posedge i_clk) begin
        if (i_res_n != 2'd0) begin
            r_q0 <= i_res0;
            r_q1 <= i_res1;
        end else if (o_valid && i_ready) begin
            r_q0 <= r_q1;
        end
        if (!i_rst_n) r_cnt <= 2'd0;
        else if (i_res_n != 2'd0) r_cnt <= i_res_n;
        else if (o_valid && i_ready) r_cnt <= r_cnt - 2'd1;
    end
endmodule

// File: rtl/ansi_terminal_cursor_engine_unit.sv
// ANSI terminal cursor engine: escape parser turning bytes into draw words.
// Each accepted byte passes through the SGR-walk and finish states before its result
// words are registered in the output buffer; SGR walks stored arguments up to an unknown one.
// A new byte is accepted only when the sequencer is idle and the sink has taken every result word.
// Synchronous active-low reset: cursor at origin, default colors, parser idle.
// Depends on atce_pkg, atce_ctrl, atce_datapath, atce_outq.
module ansi_terminal_cursor_engine_unit import atce_pkg::*; #(
    parameter int MAX_ARGS = 16,
    parameter int ARG_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // command, col, row, end_col, end_row, glyph, fg_code, bg_code, fault_code
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);
    t_cmd w_cmd;
    t_status w_st;
    t_result w_r0, w_r1, w_o;
    logic [1:0] w_n;
    logic w_busy;

    atce_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .i_res_busy(w_busy), .i_status(w_st), .o_cmd(w_cmd)
    );

    atce_datapath #(.MAX_ARGS(MAX_ARGS), .ARG_BITS(ARG_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_char(s_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_status(w_st), .o_res0(w_r0), .o_res1(w_r1), .o_res_n(w_n)
    );

    atce_outq u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_res0(w_r0), .i_res1(w_r1), .i_res_n(w_n),
        .o_busy(w_busy), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_o)
    );

    assign m_axis_tdata = {4'b0, w_o.fault_code, w_o.bg_code, w_o.fg_code, w_o.glyph,
                           w_o.end_row, w_o.end_col, w_o.row, w_o.col, w_o.command};
    assign m_axis_tlast = w_o.last;
endmodule

// File: rtl/atce_checker.sv
// Port checker for the cursor engine, bound to the top level.
// Depends on ansi_terminal_cursor_engine_unit ports only.
module atce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with pending output");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4) else $error("bad command code");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("no busy cycle");
    a_last_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown(m_axis_tlast)) else $error("tlast unknown");
endmodule

bind ansi_terminal_cursor_engine_unit atce_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
